/* hw/rtl/cld_pkg.sv */
`default_nettype none

package cld_pkg;

	// Default width of the body length and its counters.
	localparam int LENGTH_BITS_DEF = 32;

	// Header syntax.
	localparam int unsigned PREFIX_LEN = 15;
	localparam int unsigned POS_W      = $clog2(PREFIX_LEN + 1);
	localparam logic [7:0]  CH_CR      = 8'h0D;
	localparam logic [7:0]  CH_LF      = 8'h0A;
	localparam logic [7:0]  CH_SPACE   = 8'h20;
	localparam logic [7:0]  CH_ZERO    = 8'h30;
	localparam logic [7:0]  CH_NINE    = 8'h39;

	// Line terminator progress codes.
	localparam logic [1:0] TERM_NONE     = 2'd0;
	localparam logic [1:0] TERM_CR       = 2'd1;
	localparam logic [1:0] TERM_CRLF     = 2'd2;
	localparam logic [1:0] TERM_CRLFCR   = 2'd3;

	// Characters of the text "Content-Length:" by position.
	function automatic logic [7:0] prefix_char(input logic [POS_W-1:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = 8'h43; // C
			4'd1:    ch = 8'h6F; // o
			4'd2:    ch = 8'h6E; // n
			4'd3:    ch = 8'h74; // t
			4'd4:    ch = 8'h65; // e
			4'd5:    ch = 8'h6E; // n
			4'd6:    ch = 8'h74; // t
			4'd7:    ch = 8'h2D; // -
			4'd8:    ch = 8'h4C; // L
			4'd9:    ch = 8'h65; // e
			4'd10:   ch = 8'h6E; // n
			4'd11:   ch = 8'h67; // g
			4'd12:   ch = 8'h74; // t
			4'd13:   ch = 8'h68; // h
			4'd14:   ch = 8'h3A; // :
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/content_length_deframer.sv */
`default_nettype none

// Content-Length deframer.
// The input channel (in_valid, in_ready, in_byte) takes one raw stream byte
// per request. Header lines end in CR LF and a header ends at CR LF CR LF;
// the last "Content-Length:" line sets the body length, saturating at
// 2^LENGTH_BITS - 1. The output channel (out_valid, out_ready and the result
// fields) gives one request per body byte, with body_last on the final byte,
// one empty_body request for a zero length, or one header_error request for a
// header without a length line. Header bytes give no output.
// A byte is registered on acceptance and then processed against the parser
// state from the input register, and any result lands in the output register.
// One byte per cycle is sustained while no result waits for the output;
// the parser update is a single pass of short logic between the two registers.
// When the receiver stalls, the output register holds its result and the
// input register still takes a byte; a byte that would produce a result waits
// there until the output register frees up, and bytes that produce no result
// keep flowing. Reset clears both registers and puts the parser at the start
// of a header.
module content_length_deframer
	import cld_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            body_last,
	output logic            empty_body,
	output logic            header_error
);

	localparam int LB = LENGTH_BITS;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Parser state.
	logic             in_body_q;
	logic [POS_W-1:0] pos_q;
	logic             match_q;
	logic             after_q;
	logic             skip_q;
	logic             digits_q;
	logic [LB-1:0]    accum_q;
	logic [LB-1:0]    body_len_q;
	logic             seen_q;
	logic [1:0]       term_q;
	logic [LB-1:0]    remain_q;

	// Output register.
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       empty_q;
	logic       error_q;

	// Next values.
	logic             in_body_d;
	logic [POS_W-1:0] pos_d;
	logic             match_d;
	logic             after_d;
	logic             skip_d;
	logic             digits_d;
	logic [LB-1:0]    accum_d;
	logic [LB-1:0]    body_len_d;
	logic             seen_d;
	logic [1:0]       term_d;
	logic [LB-1:0]    remain_d;
	logic             produce;
	logic [7:0]       res_byte;
	logic             res_last;
	logic             res_empty;
	logic             res_error;

	logic [LB+3:0] accum_x10;
	logic          is_digit;
	logic          out_free;
	logic          advance;

	// Candidate accumulator update for the byte in the input register.
	assign is_digit  = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign accum_x10 = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0}
		+ {{LB{1'b0}}, byte_s1[3:0]};

	// Parser update for one byte.
	always_comb begin
		in_body_d  = in_body_q;
		pos_d      = pos_q;
		match_d    = match_q;
		after_d    = after_q;
		skip_d     = skip_q;
		digits_d   = digits_q;
		accum_d    = accum_q;
		body_len_d = body_len_q;
		seen_d     = seen_q;
		term_d     = term_q;
		remain_d   = remain_q;
		produce    = 1'b0;
		res_byte   = 8'h00;
		res_last   = 1'b0;
		res_empty  = 1'b0;
		res_error  = 1'b0;

		if (in_body_q) begin
			// Body byte passes through; the count reaching zero ends the body.
			if (remain_q != '0) begin
				remain_d = remain_q - LB'(1);
			end
			produce  = 1'b1;
			res_byte = byte_s1;
			if (remain_d == '0) begin
				res_last   = 1'b1;
				in_body_d  = 1'b0;
				pos_d      = '0;
				match_d    = 1'b1;
				after_d    = 1'b0;
				skip_d     = 1'b1;
				digits_d   = 1'b1;
				accum_d    = '0;
				body_len_d = '0;
				seen_d     = 1'b0;
				term_d     = TERM_NONE;
			end
		end else if (byte_s1 == CH_LF && term_q == TERM_CR) begin
			// End of a header line: latch a complete length line.
			if (match_q && pos_q == POS_W'(PREFIX_LEN) && after_q) begin
				body_len_d = accum_q;
				seen_d     = 1'b1;
			end
			pos_d    = '0;
			match_d  = 1'b1;
			after_d  = 1'b0;
			skip_d   = 1'b1;
			digits_d = 1'b1;
			accum_d  = '0;
			term_d   = TERM_CRLF;
		end else if (byte_s1 == CH_LF && term_q == TERM_CRLFCR) begin
			// End of the header: report a problem or enter the body.
			pos_d      = '0;
			match_d    = 1'b1;
			after_d    = 1'b0;
			skip_d     = 1'b1;
			digits_d   = 1'b1;
			accum_d    = '0;
			body_len_d = '0;
			seen_d     = 1'b0;
			term_d     = TERM_NONE;
			if (!seen_q) begin
				produce   = 1'b1;
				res_error = 1'b1;
			end else if (body_len_q == '0) begin
				produce   = 1'b1;
				res_empty = 1'b1;
			end else begin
				in_body_d = 1'b1;
				remain_d  = body_len_q;
			end
		end else begin
			// A held CR that turned out not to end a line counts as a line byte.
			// It never matches the prefix and is neither a space nor a digit.
			if (term_q[0] && match_q) begin
				if (pos_q != POS_W'(PREFIX_LEN)) begin
					match_d = 1'b0;
				end else begin
					after_d  = 1'b1;
					skip_d   = 1'b0;
					digits_d = 1'b0;
				end
			end
			if (byte_s1 == CH_CR) begin
				term_d = (term_q == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
			end else begin
				term_d = TERM_NONE;
				// Ordinary line byte against the state left by the held CR.
				if (match_d) begin
					if (pos_d != POS_W'(PREFIX_LEN)) begin
						if (byte_s1 == prefix_char(pos_d)) begin
							pos_d = pos_d + POS_W'(1);
						end else begin
							match_d = 1'b0;
						end
					end else begin
						after_d = 1'b1;
						if (!(skip_d && byte_s1 == CH_SPACE)) begin
							skip_d = 1'b0;
							if (digits_d) begin
								if (is_digit) begin
									if (accum_x10[LB+3:LB] != 4'd0) begin
										accum_d = '1;
									end else begin
										accum_d = accum_x10[LB-1:0];
									end
								end else begin
									digits_d = 1'b0;
								end
							end
						end
					end
				end
			end
		end
	end

	// Handshake: a byte moves on unless its result finds the output full.
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!produce || out_free);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// Parser state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q  <= 1'b0;
			pos_q      <= '0;
			match_q    <= 1'b1;
			after_q    <= 1'b0;
			skip_q     <= 1'b1;
			digits_q   <= 1'b1;
			accum_q    <= '0;
			body_len_q <= '0;
			seen_q     <= 1'b0;
			term_q     <= TERM_NONE;
			remain_q   <= '0;
		end else if (advance) begin
			in_body_q  <= in_body_d;
			pos_q      <= pos_d;
			match_q    <= match_d;
			after_q    <= after_d;
			skip_q     <= skip_d;
			digits_q   <= digits_d;
			accum_q    <= accum_d;
			body_len_q <= body_len_d;
			seen_q     <= seen_d;
			term_q     <= term_d;
			remain_q   <= remain_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && produce;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && produce) begin
			out_byte_q <= res_byte;
			last_q     <= res_last;
			empty_q    <= res_empty;
			error_q    <= res_error;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign body_last    = last_q;
	assign empty_body   = empty_q;
	assign header_error = error_q;

endmodule

`default_nettype wire
